FILE: hw/rtl/rada_pkg.sv
// Shared types and constants for the range-add difference array engine.
// Used by every module in hw/rtl; no dependencies of its own.
package rada_pkg;

    // Store geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = 7;
    localparam int DATA_W = 32;

    // Command queue between front and back (power-of-two depth)
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Item function codes
    typedef enum logic [1:0] {
        FN_LOAD = 2'd0,
        FN_ADD  = 2'd1,
        FN_EMIT = 2'd2
    } func_t;

    // Work kinds handed to the back end
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_ADD,
        CMD_EMIT
    } cmd_kind_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ADD_LO,
        BK_ADD_HI,
        BK_EMIT
    } back_state_t;

    // Input item
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
        logic [5:0]         left;
        logic [5:0]         right;
        logic signed [31:0] increment;
    } rada_in_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] element;
        logic [5:0]         element_index;
        logic               last;
    } rada_out_t;

    // Classified command: data is the load difference or the increment
    typedef struct packed {
        cmd_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   addr2;
        logic                do_hi;
        logic [DATA_W-1:0]   data;
        logic [ADDR_W-1:0]   last_idx;
    } cmd_t;

endpackage

FILE: hw/rtl/rada_front.sv
// Front end: accepts items, holds the length register and load tracking,
// and turns each item that passes its checks into a store command. Depends on rada_pkg.
module rada_front
    import rada_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rada_in_t            request,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    input  logic                q_full,
    output logic                push,
    output cmd_t                push_cmd
);

    logic [LEN_W-1:0]  length_reg;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  n_len;
    logic [LEN_W-1:0]  right_p1;
    logic              accept;

    // Length in effect: clamp to 1..DEPTH
    always_comb
    begin
        if (length_reg == '0)
            n_len = LEN_W'(1);
        else if (length_reg > LEN_W'(DEPTH))
            n_len = LEN_W'(DEPTH);
        else
            n_len = length_reg;
    end

    assign busy     = q_full;
    assign accept   = start && !q_full;
    assign right_p1 = LEN_W'(request.right) + LEN_W'(1);

    // Classify the item
    always_comb
    begin
        push       = 1'b0;
        prev_next  = prev_reg;
        count_next = count_reg;
        push_cmd.kind     = CMD_WRITE;
        push_cmd.addr     = count_reg[ADDR_W-1:0];
        push_cmd.addr2    = right_p1[ADDR_W-1:0];
        push_cmd.do_hi    = right_p1 < n_len;
        push_cmd.data     = $unsigned(request.value) - prev_reg;
        push_cmd.last_idx = ADDR_W'(n_len - LEN_W'(1));
        case (request.func)
            FN_LOAD:
            begin
                if (accept && count_reg < n_len)
                begin
                    push       = 1'b1;
                    prev_next  = $unsigned(request.value);
                    count_next = count_reg + LEN_W'(1);
                end
            end
            FN_ADD:
            begin
                push_cmd.kind = CMD_ADD;
                push_cmd.addr = request.left[ADDR_W-1:0];
                push_cmd.data = $unsigned(request.increment);
                if (accept && request.left <= request.right
                        && LEN_W'(request.right) < n_len)
                    push = 1'b1;
            end
            FN_EMIT:
            begin
                push_cmd.kind = CMD_EMIT;
                push          = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Length register and load tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_W'(DEPTH);
            prev_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                length_reg <= cfg_wr_data;
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/rada_fifo.sv
// Short command queue between the front and back ends.
// Depends on rada_pkg for the command type and depth.
module rada_fifo
    import rada_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic not_empty,
    output logic full
);

    cmd_t                  fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign head      = fifo_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == FIFO_CNT_W'(FIFO_DEPTH);

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + FIFO_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - FIFO_CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");

endmodule

FILE: hw/rtl/rada_back.sv
// Back end: owns the difference store and carries out write, range-add
// and emit commands. Depends on rada_pkg.
module rada_back
    import rada_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  logic      not_empty,
    output logic      pop,
    output logic      result_strobe,
    output rada_out_t result
);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg;
    logic              load_cmd;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              rd_ok_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata, rd_word;
    logic              strobe_reg, strobe_next;
    rada_out_t         res_reg, res_next;

    // Never-written cells read as zero
    assign rd_word = rd_ok_reg ? rdata_reg : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (not_empty)
                begin
                    case (head.kind)
                        CMD_ADD:  state_next = BK_ADD_LO;
                        CMD_EMIT: state_next = BK_EMIT;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_ADD_LO: state_next = cmd_reg.do_hi ? BK_ADD_HI : BK_IDLE;
            BK_ADD_HI: state_next = BK_IDLE;
            BK_EMIT:   state_next = (idx_reg == cmd_reg.last_idx) ? BK_IDLE : BK_EMIT;
            default:   state_next = BK_IDLE;
        endcase
    end

    // Store port control and result generation
    always_comb
    begin
        pop         = 1'b0;
        load_cmd    = 1'b0;
        we          = 1'b0;
        waddr       = cmd_reg.addr;
        wdata       = rd_word + cmd_reg.data;
        re          = 1'b0;
        raddr       = head.addr;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        strobe_next = 1'b0;
        res_next.element       = $signed(sum_reg + rd_word);
        res_next.element_index = 6'(idx_reg);
        res_next.last          = idx_reg == cmd_reg.last_idx;
        case (state_reg)
            BK_IDLE:
            begin
                if (not_empty)
                begin
                    pop      = 1'b1;
                    load_cmd = 1'b1;
                    case (head.kind)
                        CMD_WRITE:
                        begin
                            we    = 1'b1;
                            waddr = head.addr;
                            wdata = head.data;
                        end
                        CMD_ADD:
                        begin
                            re = 1'b1;
                        end
                        CMD_EMIT:
                        begin
                            re       = 1'b1;
                            raddr    = '0;
                            idx_next = '0;
                            sum_next = '0;
                        end
                        default:
                        begin
                            re = 1'b0;
                        end
                    endcase
                end
            end
            BK_ADD_LO:
            begin
                we    = 1'b1;
                re    = cmd_reg.do_hi;
                raddr = cmd_reg.addr2;
            end
            BK_ADD_HI:
            begin
                we    = 1'b1;
                waddr = cmd_reg.addr2;
                wdata = rd_word - cmd_reg.data;
            end
            BK_EMIT:
            begin
                strobe_next = 1'b1;
                sum_next    = sum_reg + rd_word;
                idx_next    = idx_reg + ADDR_W'(1);
                raddr       = idx_reg + ADDR_W'(1);
                re          = idx_reg != cmd_reg.last_idx;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Difference store, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            if (re)
                rd_ok_reg <= valid_reg[raddr];
        end
    end

    // Sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_cmd)
            cmd_reg <= head;
        idx_reg <= idx_next;
        sum_reg <= sum_next;
        res_reg <= res_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

    a_emit_streams: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |=> result_strobe)
        else $error("emit run broken before last element");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !result_strobe)
        else $error("result after last element");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last)
            |=> result.element_index == 6'($past(result.element_index) + 6'd1))
        else $error("emit index not consecutive");

endmodule

FILE: hw/rtl/range_add_difference_array.sv
// Top level of the range-add difference array engine.
// Instantiates rada_front, rada_fifo and rada_back; depends on rada_pkg.
//
//  channel   | ports                              | handshake
//  ----------+------------------------------------+-------------------------------
//  item in   | start, busy, request (rada_in_t)   | taken when start && !busy
//  result    | result_strobe, result (rada_out_t) | valid with result_strobe, no stall
//  config    | cfg_wr_en, cfg_wr_data             | written when cfg_wr_en
//
// A load is a single store write from the idle state. A range add reads and
// then writes the left-bound cell, and the cell past the right bound when that
// one is updated: each touch of the store (one read port, one write port) is a
// read followed by a write. An emit reads the first store cell from the idle
// state, then gives one element per cycle. The front end takes an item per
// cycle until the two-entry command queue fills; busy is high while it is full.
// Reset clears the store's written flags at once; no clearing pass is needed.
module range_add_difference_array
    import rada_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rada_in_t         request,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    output logic             result_strobe,
    output rada_out_t        result
);

    logic push, pop, q_full, q_not_empty;
    cmd_t push_cmd, q_head;

    rada_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    rada_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .not_empty(q_not_empty),
        .full     (q_full)
    );

    rada_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .not_empty    (q_not_empty),
        .pop          (pop),
        .result_strobe(result_strobe),
        .result       (result)
    );

endmodule
